// File: hdl/sbq_eq_pkg.sv
package sbq_eq_pkg;

    // field widths fixed by the interface
    localparam int SAMPLE_BITS = 24;
    localparam int COEFF_BITS  = 32;
    localparam int OPCODE_W    = 2;
    localparam int BAND_SEL_W  = 3;
    localparam int COEF_SEL_W  = 3;
    localparam int ACT_W       = 4;
    localparam int EN_BITS     = 8;
    localparam int EN_IDX_W    = 3;

    // cascade geometry
    localparam int BANDS      = 8;
    localparam int NCOEF      = 5;
    localparam int NHIST      = 4;
    localparam int BAND_W     = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int CNT_W      = ($clog2(BANDS + 1) > ACT_W) ? $clog2(BANDS + 1) : ACT_W;
    localparam int COEF_DEPTH = BANDS * NCOEF;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int HIDX_W     = 2;
    localparam int HIST_DEPTH = BANDS * NHIST;
    localparam int HIST_AW    = BAND_W + HIDX_W;

    // arithmetic
    localparam int COEFF_FRAC = COEFF_BITS - 6;
    localparam int PROD_W     = COEFF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS   = 64;

    localparam logic [COEFF_BITS-1:0] COEFF_ONE =
        {{(COEFF_BITS-1){1'b0}}, 1'b1} << COEFF_FRAC;
    localparam logic signed [ACC_BITS-1:0] ROUND_ADD =
        {{(ACC_BITS-1){1'b0}}, 1'b1} << (COEFF_FRAC - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_MAX =
        {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SAT_MIN = ~SAT_MAX;

    // band sequencer steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_ISSUE     = 3'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_FIRST = 3'd1;
    localparam logic [STEP_W-1:0] STEP_ACC_FIRST = 3'd2;
    localparam logic [STEP_W-1:0] STEP_WR_X1     = 3'd3;
    localparam logic [STEP_W-1:0] STEP_COEF_LAST = 3'd4;
    localparam logic [STEP_W-1:0] STEP_MUL_LAST  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_ACC_LAST  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_LAST      = 3'd7;
    // products from this step on are the feedback terms
    localparam logic [STEP_W-1:0] STEP_SUB_FIRST = 3'd5;

    // history slots within one band and channel
    localparam logic [HIDX_W-1:0] HIDX_X1 = 2'd0;
    localparam logic [HIDX_W-1:0] HIDX_X2 = 2'd1;
    localparam logic [HIDX_W-1:0] HIDX_Y1 = 2'd2;
    localparam logic [HIDX_W-1:0] HIDX_Y2 = 2'd3;

    // request codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_PROCESS     = 2'd0,
        OP_COEF_WRITE  = 2'd1,
        OP_CLEAR       = 2'd2
    } opcode_t;

    // register map
    localparam int PADDR_W = 3;
    localparam logic REG_ACTIVE_BANDS = 1'b0;
    localparam logic REG_BAND_ENABLE  = 1'b1;

    // sequencer to lane control
    typedef struct packed {
        logic              run;
        logic              load;
        logic              clear;
        logic [BAND_W-1:0] band;
        logic [STEP_W-1:0] step;
    } lane_ctrl_t;

    // coefficient store write request
    typedef struct packed {
        logic                  en;
        logic [COEF_AW-1:0]    addr;
        logic [COEFF_BITS-1:0] data;
    } coef_wr_t;

endpackage

// File: hdl/sbq_eq_coef_store.sv
module sbq_eq_coef_store
    import sbq_eq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  coef_wr_t              wr,
    input  logic                  rd_en,
    input  logic [COEF_AW-1:0]    rd_addr,
    input  logic                  rd_is_b0,
    output logic [COEFF_BITS-1:0] rd_data
);

    logic [COEFF_BITS-1:0] coef_mem [COEF_DEPTH];
    logic [COEF_DEPTH-1:0] coef_vld_reg;
    logic [COEFF_BITS-1:0] rd_data_reg;

    // written entries are marked, the rest read as their reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
        end
        else if (wr.en)
        begin
            coef_vld_reg[wr.addr] <= 1'b1;
        end
    end

    // storage array with registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            coef_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            if (coef_vld_reg[rd_addr])
            begin
                rd_data_reg <= coef_mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= rd_is_b0 ? COEFF_ONE : '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/sbq_eq_lane.sv
module sbq_eq_lane
    import sbq_eq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lane_ctrl_t             ctrl,
    input  logic                   hist_wr_ok,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [COEFF_BITS-1:0]  coef_rd,
    output logic [SAMPLE_BITS-1:0] result
);

    logic [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0]  hist_vld_reg;
    logic [SAMPLE_BITS-1:0] hist_rd_reg;

    logic [SAMPLE_BITS-1:0]     x_reg;
    logic [SAMPLE_BITS-1:0]     x_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [ACC_BITS-1:0] acc_next;

    logic                       mul_en;
    logic                       acc_en;
    logic [SAMPLE_BITS-1:0]     operand;
    logic signed [ACC_BITS-1:0] prod_ext;
    logic signed [ACC_BITS-1:0] acc_base;
    logic signed [ACC_BITS-1:0] rounded;
    logic signed [ACC_BITS-1:0] shifted;
    logic [SAMPLE_BITS-1:0]     y;
    logic [HIST_AW-1:0]         hist_ra;
    logic [HIST_AW-1:0]         hist_wa;
    logic [SAMPLE_BITS-1:0]     hist_wd;
    logic                       hist_hit;
    logic                       hist_we;
    logic [HIDX_W-1:0]          hist_widx;

    // one multiply per step, one accumulate per step behind it
    always_comb
    begin
        mul_en   = ctrl.run && (ctrl.step >= STEP_MUL_FIRST) && (ctrl.step <= STEP_MUL_LAST);
        acc_en   = ctrl.run && (ctrl.step >= STEP_ACC_FIRST) && (ctrl.step <= STEP_ACC_LAST);
        operand  = (ctrl.step == STEP_MUL_FIRST) ? x_reg : hist_rd_reg;
        prod_next = PROD_W'($signed(coef_rd)) * PROD_W'($signed(operand));
        prod_ext = ACC_BITS'(prod_reg);
        acc_base = (ctrl.step == STEP_ACC_FIRST) ? '0 : acc_reg;
        if (ctrl.step >= STEP_SUB_FIRST)
        begin
            acc_next = acc_base - prod_ext;
        end
        else
        begin
            acc_next = acc_base + prod_ext;
        end
    end

    // round half up, then saturate to the sample range
    always_comb
    begin
        rounded = acc_reg + ROUND_ADD;
        shifted = rounded >>> COEFF_FRAC;
        if (shifted > SAT_MAX)
        begin
            y = SAMPLE_BITS'(SAT_MAX);
        end
        else if (shifted < SAT_MIN)
        begin
            y = SAMPLE_BITS'(SAT_MIN);
        end
        else
        begin
            y = SAMPLE_BITS'(shifted);
        end
    end

    // history shuffle spread over the band steps
    always_comb
    begin
        hist_ra   = {ctrl.band, HIDX_W'(ctrl.step - STEP_MUL_FIRST)};
        hist_hit  = 1'b1;
        hist_widx = HIDX_X1;
        hist_wd   = x_reg;
        case (ctrl.step)
            STEP_ACC_FIRST:
            begin
                hist_widx = HIDX_X2;
                hist_wd   = hist_rd_reg;
            end
            STEP_WR_X1:
            begin
                hist_widx = HIDX_X1;
                hist_wd   = x_reg;
            end
            STEP_COEF_LAST:
            begin
                hist_widx = HIDX_Y2;
                hist_wd   = hist_rd_reg;
            end
            STEP_LAST:
            begin
                hist_widx = HIDX_Y1;
                hist_wd   = y;
            end
            default:
            begin
                hist_hit = 1'b0;
            end
        endcase
        hist_wa = {ctrl.band, hist_widx};
        hist_we = ctrl.run && hist_wr_ok && hist_hit;
    end

    // running sample: input at load, band output after each band
    always_comb
    begin
        x_next = x_reg;
        if (ctrl.load)
        begin
            x_next = sample;
        end
        else if (ctrl.run && (ctrl.step == STEP_LAST))
        begin
            x_next = y;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    // history valid bits, cleared at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            hist_vld_reg <= '0;
        end
        else if (hist_we)
        begin
            hist_vld_reg[hist_wa] <= 1'b1;
        end
    end

    // history array with registered read
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_wa] <= hist_wd;
        end
        hist_rd_reg <= hist_vld_reg[hist_ra] ? hist_mem[hist_ra] : '0;
    end

    assign result = x_reg;

endmodule

// File: hdl/stereo_biquad_cascade_eq.sv
// Stereo eight-band equaliser built from cascaded direct-form-1 biquads. A process
// request runs the frame through the first active_bands sections, skipping those whose
// band_enable bit is clear; left and right run in two lanes side by side, each with one
// 32x24 multiply-accumulate that forms the five products of a band one after another.
// Coefficient writes and history clears give no result. Coefficients are Q6.26, samples
// Q1.23, each band output saturates to 24 bits. After reset every band passes the signal
// through unchanged (b0 = 1.0), and right_out is zero for frames without a right channel.
// A finished frame waits in the output register while the next request is taken.
module stereo_biquad_cascade_eq
    import sbq_eq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OPCODE_W-1:0]    opcode,
    input  logic [SAMPLE_BITS-1:0] left_sample,
    input  logic [SAMPLE_BITS-1:0] right_sample,
    input  logic                   right_present,
    input  logic                   frame_last,
    input  logic [BAND_SEL_W-1:0]  band_select,
    input  logic [COEF_SEL_W-1:0]  coeff_select,
    input  logic [COEFF_BITS-1:0]  coeff_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] left_out,
    output logic [SAMPLE_BITS-1:0] right_out,
    output logic                   out_last
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    band_cnt_reg;
    logic [CNT_W-1:0]    band_cnt_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                rp_reg;
    logic                last_reg;
    logic [ACT_W-1:0]    active_bands_reg;
    logic [EN_BITS-1:0]  band_enable_reg;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SAMPLE_BITS-1:0] left_out_reg;
    logic [SAMPLE_BITS-1:0] right_out_reg;
    logic                   out_last_reg;

    logic                   cfg_wr;
    logic                   accept;
    logic                   band_lim_hit;
    logic                   band_en;
    logic [CNT_W-1:0]       band_lim;
    logic                   out_load;
    lane_ctrl_t             ctrl;
    coef_wr_t               coef_wr;
    logic                   coef_rd_en;
    logic [COEF_AW-1:0]     coef_rd_addr;
    logic [COEFF_BITS-1:0]  coef_rd;
    logic [SAMPLE_BITS-1:0] left_y;
    logic [SAMPLE_BITS-1:0] right_y;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_bands_reg <= '0;
            band_enable_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_ACTIVE_BANDS: active_bands_reg <= pwdata[ACT_W-1:0];
                REG_BAND_ENABLE:  band_enable_reg  <= pwdata[EN_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ACTIVE_BANDS: prdata = 32'(active_bands_reg);
            REG_BAND_ENABLE:  prdata = 32'(band_enable_reg);
            default:          prdata = '0;
        endcase
    end

    // band sequencer
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        band_lim = (CNT_W'(active_bands_reg) > CNT_W'(BANDS)) ? CNT_W'(BANDS)
                                                              : CNT_W'(active_bands_reg);
        band_lim_hit = (band_cnt_reg >= band_lim);
        band_en = (band_cnt_reg < CNT_W'(EN_BITS))
                  && band_enable_reg[band_cnt_reg[EN_IDX_W-1:0]];
    end

    always_comb
    begin
        state_next    = state_reg;
        band_cnt_next = band_cnt_reg;
        step_next     = step_reg;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_PROCESS))
                begin
                    state_next    = ST_RUN;
                    band_cnt_next = '0;
                    step_next     = STEP_ISSUE;
                end
            end
            ST_RUN:
            begin
                if (step_reg != STEP_ISSUE)
                begin
                    step_next = step_reg + STEP_W'(1);
                    if (step_reg == STEP_LAST)
                    begin
                        band_cnt_next = band_cnt_reg + CNT_W'(1);
                    end
                end
                else if (band_lim_hit)
                begin
                    state_next = ST_DONE;
                end
                else if (!band_en)
                begin
                    band_cnt_next = band_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    step_next = STEP_MUL_FIRST;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            band_cnt_reg <= '0;
            step_reg     <= STEP_ISSUE;
        end
        else
        begin
            state_reg    <= state_next;
            band_cnt_reg <= band_cnt_next;
            step_reg     <= step_next;
        end
    end

    // frame side information
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rp_reg   <= right_present;
            last_reg <= frame_last;
        end
    end

    // lane control
    always_comb
    begin
        ctrl.run   = (state_reg == ST_RUN);
        ctrl.load  = accept && (opcode == OP_PROCESS);
        ctrl.clear = accept && (opcode == OP_CLEAR);
        ctrl.band  = band_cnt_reg[BAND_W-1:0];
        ctrl.step  = step_reg;
    end

    // coefficient store access
    always_comb
    begin
        coef_wr.en   = accept && (opcode == OP_COEF_WRITE)
                       && (coeff_select < COEF_SEL_W'(NCOEF))
                       && ({1'b0, band_select} < (BAND_SEL_W + 1)'(BANDS));
        coef_wr.addr = COEF_AW'(band_select) * COEF_AW'(NCOEF) + COEF_AW'(coeff_select);
        coef_wr.data = coeff_value;
        coef_rd_en   = (state_reg == ST_RUN) && (step_reg <= STEP_COEF_LAST)
                       && !band_lim_hit;
        coef_rd_addr = COEF_AW'(band_cnt_reg[BAND_W-1:0]) * COEF_AW'(NCOEF)
                       + COEF_AW'(step_reg);
    end

    sbq_eq_coef_store u_coef_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (coef_wr),
        .rd_en    (coef_rd_en),
        .rd_addr  (coef_rd_addr),
        .rd_is_b0 (step_reg == STEP_ISSUE),
        .rd_data  (coef_rd)
    );

    // left and right lanes
    sbq_eq_lane u_lane_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .hist_wr_ok (1'b1),
        .sample     (left_sample),
        .coef_rd    (coef_rd),
        .result     (left_y)
    );

    sbq_eq_lane u_lane_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .hist_wr_ok (rp_reg),
        .sample     (right_sample),
        .coef_rd    (coef_rd),
        .result     (right_y)
    );

    // merge stage and output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_out_reg  <= left_y;
            right_out_reg <= rp_reg ? right_y : '0;
            out_last_reg  <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;
    assign out_last  = out_last_reg;

    // a band only steps past issue when it is in range and enabled
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && step_reg != STEP_ISSUE) |-> (!band_lim_hit && band_en))
        else $error("band sequencer stepping through a bypassed band");

    // a process request starts the cascade on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == OP_PROCESS) |=> (state_reg == ST_RUN))
        else $error("process request did not start the cascade");

    // results only appear from the merge stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the merge stage");

endmodule
